[rtl/hvng_pkg.sv]
// ----------------------------------------------------------------------------
// hvng_pkg
// Shared types and constants of the heightfield vertex normal generator.
// ----------------------------------------------------------------------------
package hvng_pkg;

  localparam int DEF_GRID_SIDE = 256;
  localparam int COORD_W       = 8;
  localparam int HEIGHT_W      = 16;
  localparam int SPACING_W     = 16;
  localparam int POS_W         = 24;
  localparam int NORM_W        = 16;
  localparam int NORM_Y_W      = 15;
  localparam int TEX_W         = 17;

  localparam int DIFF_W        = 17;
  localparam int SQ_W          = 34;
  localparam int LEN2_W        = 36;
  localparam int ACC_W         = 70;
  localparam int MAG_W         = 15;
  localparam int MAG_TOP       = MAG_W - 1;
  localparam int NUM_LANES     = 3;
  localparam int TEX_ENTRIES   = 256;

  localparam logic [SPACING_W-1:0] SPACING_RESET = 16'd128;
  localparam logic [MAG_W-1:0]     NORM_ONE      = 15'd16384;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // fetch order of the five samples
  localparam logic [2:0] FETCH_C    = 3'd0;
  localparam logic [2:0] FETCH_L    = 3'd1;
  localparam logic [2:0] FETCH_R    = 3'd2;
  localparam logic [2:0] FETCH_D    = 3'd3;
  localparam logic [2:0] FETCH_U    = 3'd4;
  localparam logic [2:0] FETCH_LAST = 3'd5;

  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SQUARE,
    ST_SUM,
    ST_ITER,
    ST_DONE
  } state_t;

endpackage

[rtl/hvng_ram.sv]
// ----------------------------------------------------------------------------
// hvng_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module hvng_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/heightfield_vertex_normal_generator.sv]
// ----------------------------------------------------------------------------
// heightfield_vertex_normal_generator
// Height grid store with vertex position, normal and texture coordinate read.
// ----------------------------------------------------------------------------
// A write item stores one height sample. A read item fetches the centre and
// four neighbours through the single read port of the height memory, forms
// the squared differences and their sum, runs a bit-per-cycle normalizer
// whose three lanes handle the normal components side by side, and then
// loads the output register once it is free. The input stalls while a read
// is in progress, so no new item is taken until the read is through; a
// finished vertex waits in the output register while the next item is taken.
// Items whose column or row lies outside the grid are dropped.
module heightfield_vertex_normal_generator #(
  parameter int GRID_SIDE = hvng_pkg::DEF_GRID_SIDE
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [hvng_pkg::SPACING_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        req_type,
  input  logic [hvng_pkg::COORD_W-1:0]  col,
  input  logic [hvng_pkg::COORD_W-1:0]  row,
  input  logic signed [hvng_pkg::HEIGHT_W-1:0] height_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [hvng_pkg::POS_W-1:0]  pos_x,
  output logic signed [hvng_pkg::HEIGHT_W-1:0] pos_y,
  output logic signed [hvng_pkg::POS_W-1:0]  pos_z,
  output logic signed [hvng_pkg::NORM_W-1:0] norm_x,
  output logic [hvng_pkg::NORM_Y_W-1:0]      norm_y,
  output logic signed [hvng_pkg::NORM_W-1:0] norm_z,
  output logic [hvng_pkg::TEX_W-1:0]         tex_u,
  output logic [hvng_pkg::TEX_W-1:0]         tex_v
);

  import hvng_pkg::*;

  localparam int DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int HALF  = GRID_SIDE / 2;
  localparam int OFF_W = 12;
  localparam int PROD_W = OFF_W + SPACING_W + 1;

  state_t state, state_next;

  logic [SPACING_W-1:0] spacing;
  logic [COORD_W-1:0]   col_q, row_q;
  logic [2:0]           fetch_cnt;
  logic signed [HEIGHT_W-1:0] h [5];

  logic               in_range, accept;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [HEIGHT_W-1:0] rd_data;

  logic signed [DIFF_W-1:0] nx, nz;
  logic [DIFF_W-1:0]        ny;
  logic signed [2*DIFF_W-1:0] sq_xs, sq_zs;
  logic [SQ_W-1:0]          sq [NUM_LANES];
  logic                     neg_x, neg_z;
  logic [LEN2_W-1:0]        len2;
  logic [ACC_W-1:0]         lim [NUM_LANES];
  logic [ACC_W-1:0]         acc_u [NUM_LANES];
  logic [ACC_W-1:0]         acc_v [NUM_LANES];
  logic [MAG_W-1:0]         mag [NUM_LANES];
  logic [3:0]               bit_idx;

  logic [ACC_W-1:0] try_u [NUM_LANES];
  logic [ACC_W-1:0] try_v [NUM_LANES];
  logic             take  [NUM_LANES];

  logic signed [OFF_W-1:0]  off_c, off_r;
  logic signed [PROD_W-1:0] prod_c, prod_r;
  logic signed [POS_W-1:0]  px, pz;

  logic [TEX_W-1:0] tex_lut [TEX_ENTRIES];

  // --------------------------------------------------------------------------
  genvar gi;
  generate
    for (gi = 0; gi < TEX_ENTRIES; gi++) begin : g_tex
      localparam int TEX_VAL = (gi * 131072 + (GRID_SIDE - 1)) / (2 * (GRID_SIDE - 1));
      assign tex_lut[gi] = TEX_W'(TEX_VAL);
    end
  endgenerate

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi_lim;
    logic signed [PROD_W-1:0] lo_lim;
    hi_lim = PROD_W'(8388607);
    lo_lim = -PROD_W'(8388608);
    if (v > hi_lim) begin
      return POS_W'(hi_lim);
    end else if (v < lo_lim) begin
      return POS_W'(lo_lim);
    end
    return POS_W'(v);
  endfunction

  // --------------------------------------------------------------------------
  assign in_range = (32'(col) < GRID_SIDE) && (32'(row) < GRID_SIDE);
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign wr_addr  = AW'(AW'(row) * AW'(GRID_SIDE) + AW'(col));

  always_comb begin
    logic [COORD_W-1:0] c_sel, r_sel;
    c_sel = col_q;
    r_sel = row_q;
    case (fetch_cnt)
      FETCH_L: if (col_q != '0) c_sel = col_q - 1'b1;
      FETCH_R: if (32'(col_q) < GRID_SIDE - 1) c_sel = col_q + 1'b1;
      FETCH_D: if (row_q != '0) r_sel = row_q - 1'b1;
      FETCH_U: if (32'(row_q) < GRID_SIDE - 1) r_sel = row_q + 1'b1;
      default: begin
      end
    endcase
    rd_addr = AW'(AW'(r_sel) * AW'(GRID_SIDE) + AW'(c_sel));
  end

  hvng_ram #(
    .WIDTH(HEIGHT_W),
    .DEPTH(DEPTH)
  ) u_height_ram (
    .clk    (clk),
    .wr_en  (accept && in_range && (req_type == REQ_WRITE)),
    .wr_addr(wr_addr),
    .wr_data(height_in),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // --------------------------------------------------------------------------
  assign nx    = DIFF_W'(h[FETCH_L]) - DIFF_W'(h[FETCH_R]);
  assign nz    = DIFF_W'(h[FETCH_D]) - DIFF_W'(h[FETCH_U]);
  assign ny    = {spacing, 1'b0};
  assign sq_xs = nx * nx;
  assign sq_zs = nz * nz;

  assign off_c  = $signed(OFF_W'(col_q)) - OFF_W'(HALF);
  assign off_r  = $signed(OFF_W'(row_q)) - OFF_W'(HALF);
  assign prod_c = PROD_W'(off_c) * $signed({1'b0, spacing});
  assign prod_r = PROD_W'(off_r) * $signed({1'b0, spacing});

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      try_u[k] = acc_u[k] + (acc_v[k] << (bit_idx + 1'b1))
               + (ACC_W'(len2) << {bit_idx, 1'b0});
      try_v[k] = acc_v[k] + (ACC_W'(len2) << bit_idx);
      take[k]  = ((try_u[k] << 2) - (try_v[k] << 2) + ACC_W'(len2)) <= lim[k];
    end
  end

  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept && in_range && (req_type == REQ_READ)) state_next = ST_FETCH;
      ST_FETCH:  if (fetch_cnt == FETCH_LAST) state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_SUM;
      ST_SUM:    state_next = ST_ITER;
      ST_ITER:   if (bit_idx == '0) state_next = ST_DONE;
      ST_DONE:   if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing   <= SPACING_RESET;
      out_valid <= 1'b0;
      fetch_cnt <= FETCH_C;
      bit_idx   <= '0;
    end else begin
      if (cfg_wr_en) begin
        spacing <= cfg_wr_data;
      end
      if (state == ST_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          fetch_cnt <= FETCH_C;
        end
        ST_FETCH: begin
          fetch_cnt <= fetch_cnt + 1'b1;
        end
        ST_SUM: begin
          bit_idx <= 4'(MAG_TOP);
        end
        ST_ITER: begin
          bit_idx <= bit_idx - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_q <= col;
      row_q <= row;
    end
    if (state == ST_FETCH && fetch_cnt != FETCH_C) begin
      h[fetch_cnt - 1'b1] <= rd_data;
    end
    if (state == ST_SQUARE) begin
      sq[LANE_X] <= SQ_W'(sq_xs);
      sq[LANE_Y] <= SQ_W'(ny) * SQ_W'(ny);
      sq[LANE_Z] <= SQ_W'(sq_zs);
      neg_x      <= nx[DIFF_W-1];
      neg_z      <= nz[DIFF_W-1];
      px         <= sat_pos(prod_c);
      pz         <= sat_pos(prod_r);
    end
    if (state == ST_SUM) begin
      len2 <= LEN2_W'(sq[LANE_X]) + LEN2_W'(sq[LANE_Y]) + LEN2_W'(sq[LANE_Z]);
      for (int k = 0; k < NUM_LANES; k++) begin
        lim[k]   <= ACC_W'(sq[k]) << 30;
        acc_u[k] <= '0;
        acc_v[k] <= '0;
        mag[k]   <= '0;
      end
    end
    if (state == ST_ITER) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        if (take[k]) begin
          acc_u[k]        <= try_u[k];
          acc_v[k]        <= try_v[k];
          mag[k][bit_idx] <= 1'b1;
        end
      end
    end
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      pos_x <= px;
      pos_y <= h[FETCH_C];
      pos_z <= pz;
      tex_u <= tex_lut[col_q];
      tex_v <= tex_lut[row_q];
      if (len2 == '0) begin
        norm_x <= '0;
        norm_y <= NORM_ONE;
        norm_z <= '0;
      end else begin
        norm_x <= neg_x ? -NORM_W'(mag[LANE_X]) : NORM_W'(mag[LANE_X]);
        norm_y <= mag[LANE_Y];
        norm_z <= neg_z ? -NORM_W'(mag[LANE_Z]) : NORM_W'(mag[LANE_Z]);
      end
    end
  end

`ifndef SYNTHESIS
  a_read_starts_fetch: assert property (@(posedge clk) disable iff (rst)
    (accept && in_range && req_type == REQ_READ) |=> (state == ST_FETCH))
    else $error("read item did not start a fetch");

  a_done_loads_output: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !(out_valid && out_stall)) |=> out_valid)
    else $error("finished vertex not presented");

  a_norm_y_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (norm_y <= NORM_ONE))
    else $error("normal y component above one");
`endif

endmodule
